// ===== rtl/core/ats_pkg.sv =====
// ----------------------------------------------------------------------------
// ats_pkg
// Shared types, token kinds and character tables of the token scanner.
// ----------------------------------------------------------------------------
package ats_pkg;

   localparam int NUM_KEYWORDS = 5;
   localparam int QUEUE_DEPTH  = 4;

   localparam logic [3:0] KIND_IDENT       = 4'd0;
   localparam logic [3:0] KIND_PUNCT_FIRST = 4'd6;
   localparam logic [3:0] KIND_EOF         = 4'd15;

   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_LF      = 8'h0A;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_COMMENT = 8'h23;

   // Punctuation characters in token-kind order: ( ) { } ; : = * ,
   localparam logic [7:0] PUNCT_CHARS [9] = '{
      8'h28, 8'h29, 8'h7B, 8'h7D, 8'h3B, 8'h3A, 8'h3D, 8'h2A, 8'h2C
   };

   // Keywords header, macro, input, opcode, output, padded with zeros.
   localparam logic [7:0] KW_CHARS [NUM_KEYWORDS][8] = '{
      '{8'h68, 8'h65, 8'h61, 8'h64, 8'h65, 8'h72, 8'h00, 8'h00},
      '{8'h6D, 8'h61, 8'h63, 8'h72, 8'h6F, 8'h00, 8'h00, 8'h00},
      '{8'h69, 8'h6E, 8'h70, 8'h75, 8'h74, 8'h00, 8'h00, 8'h00},
      '{8'h6F, 8'h70, 8'h63, 8'h6F, 8'h64, 8'h65, 8'h00, 8'h00},
      '{8'h6F, 8'h75, 8'h74, 8'h70, 8'h75, 8'h74, 8'h00, 8'h00}
   };
   localparam logic [2:0] KW_LEN [NUM_KEYWORDS] = '{3'd6, 3'd5, 3'd5, 3'd6, 3'd6};

   typedef struct packed {
      logic [3:0]  kind;
      logic [15:0] offset;
      logic [15:0] length;
      logic [15:0] line;
      logic [15:0] column;
      logic        last;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   typedef struct packed {
      logic [2:0] count;
   } queue_status_type;

   typedef struct packed {
      logic       hit;
      logic [3:0] index;
   } punct_type;

   function automatic punct_type punct_lookup(input logic [7:0] c);
      punct_type p;
      p = '0;
      for (int i = 0; i < 9; i++) begin
         if (!p.hit && PUNCT_CHARS[i] == c) begin
            p.hit   = 1'b1;
            p.index = 4'(i);
         end
      end
      return p;
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_CR) || (c == CHAR_LF);
   endfunction

   // Keywords that still agree with a word whose character at pos is c.
   // pos is 7 for every position past the longest keyword.
   function automatic logic [NUM_KEYWORDS-1:0] keyword_keep(input logic [7:0] c,
                                                            input logic [2:0] pos);
      logic [NUM_KEYWORDS-1:0] keep;
      for (int k = 0; k < NUM_KEYWORDS; k++) begin
         keep[k] = (pos < KW_LEN[k]) && (KW_CHARS[k][pos] == c);
      end
      return keep;
   endfunction

endpackage

// ===== rtl/core/ats_scanner.sv =====
// ----------------------------------------------------------------------------
// ats_scanner
// Input register, scanner state and the per-character token decision.
// ----------------------------------------------------------------------------
module ats_scanner #(
   parameter int CW = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_char,
   input  logic               req_eot,
   input  logic               space_ok,
   output ats_pkg::push_type  push
);
   import ats_pkg::*;

   localparam logic [CW-1:0] CNT_ONE = CW'(1);

   logic                    in_valid_ff, in_valid_in;
   logic [7:0]              in_char_ff;
   logic                    in_eot_ff;
   logic                    process;

   logic                    in_word_ff, in_word_in;
   logic                    in_comment_ff, in_comment_in;
   logic [CW-1:0]           word_start_ff, word_start_in;
   logic [CW-1:0]           word_length_ff, word_length_in;
   logic [NUM_KEYWORDS-1:0] keyword_mask_ff, keyword_mask_in;
   logic [CW-1:0]           line_ff, line_in;
   logic [CW-1:0]           column_ff, column_in;
   logic [CW-1:0]           offset_ff, offset_in;

   logic [CW-1:0]           offset_inc;
   logic [CW-1:0]           column_inc;
   logic [2:0]              match_pos;
   logic [3:0]              word_kind;
   result_type              word_token;
   punct_type               punct;
   logic                    word_char;
   push_type                push_in;

   function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
      return (v == '1) ? v : v + CNT_ONE;
   endfunction

   function automatic logic [15:0] clamp16(input logic [CW-1:0] v);
      logic [31:0] wide;
      wide = 32'(v);
      return (wide > 32'h0000_FFFF) ? 16'hFFFF : wide[15:0];
   endfunction

   function automatic result_type make_token(input logic [3:0] kind,
                                             input logic [CW-1:0] off,
                                             input logic [CW-1:0] len,
                                             input logic [CW-1:0] line,
                                             input logic [CW-1:0] col);
      result_type r;
      r.kind   = kind;
      r.offset = clamp16(off);
      r.length = clamp16(len);
      r.line   = clamp16(line);
      r.column = clamp16(col);
      r.last   = 1'b0;
      return r;
   endfunction

   assign process     = in_valid_ff && space_ok;
   assign req_tready  = !in_valid_ff || process;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   assign offset_inc = sat_inc(offset_ff);
   assign column_inc = sat_inc(column_ff);
   assign match_pos  = (word_length_ff < CW'(6)) ? word_length_ff[2:0] : 3'd7;
   assign punct      = punct_lookup(in_char_ff);
   assign word_char  = !is_blank(in_char_ff) && (in_char_ff != CHAR_COMMENT) && !punct.hit;

   always_comb begin
      word_kind = KIND_IDENT;
      for (int k = 0; k < NUM_KEYWORDS; k++) begin
         if (keyword_mask_ff[k] && (word_length_ff == CW'(KW_LEN[k]))) begin
            word_kind = 4'(k + 1);
         end
      end
   end

   // The pending word is reported with the column before this character.
   assign word_token = make_token(word_kind, word_start_ff, word_length_ff, line_ff, column_ff);

   always_comb begin
      in_word_in      = in_word_ff;
      in_comment_in   = in_comment_ff;
      word_start_in   = word_start_ff;
      word_length_in  = word_length_ff;
      keyword_mask_in = keyword_mask_ff;
      line_in         = line_ff;
      column_in       = column_ff;
      offset_in       = offset_ff;
      push_in         = '0;

      if (process) begin
         if (in_eot_ff) begin
            if (in_word_ff) begin
               push_in.first = word_token;
               push_in.count = 2'd1;
            end
            if (in_word_ff) begin
               push_in.second = make_token(KIND_EOF, offset_ff, '0, line_ff, column_inc);
            end else begin
               push_in.first  = make_token(KIND_EOF, offset_ff, '0, line_ff, column_inc);
            end
            push_in.count   = push_in.count + 2'd1;
            in_word_in      = 1'b0;
            keyword_mask_in = '1;
            in_comment_in   = 1'b0;
            column_in       = column_inc;
         end else if (in_comment_ff && (in_char_ff != CHAR_LF)) begin
            offset_in = offset_inc;
            column_in = column_inc;
         end else if (in_word_ff && word_char) begin
            keyword_mask_in = keyword_mask_ff & keyword_keep(in_char_ff, match_pos);
            word_length_in  = sat_inc(word_length_ff);
            offset_in       = offset_inc;
            column_in       = column_inc;
         end else begin
            in_comment_in = 1'b0;
            if (in_word_ff) begin
               push_in.first   = word_token;
               push_in.count   = 2'd1;
               in_word_in      = 1'b0;
               keyword_mask_in = '1;
            end
            offset_in = offset_inc;
            column_in = column_inc;
            priority if (in_char_ff == CHAR_LF) begin
               // Column restarts at zero and the advance makes it one.
               line_in   = sat_inc(line_ff);
               column_in = CNT_ONE;
            end else if (is_blank(in_char_ff)) begin
               column_in = column_inc;
            end else if (in_char_ff == CHAR_COMMENT) begin
               in_comment_in = 1'b1;
            end else if (punct.hit) begin
               if (in_word_ff) begin
                  push_in.second = make_token(KIND_PUNCT_FIRST + punct.index, offset_ff,
                                              CNT_ONE, line_ff, column_inc);
               end else begin
                  push_in.first  = make_token(KIND_PUNCT_FIRST + punct.index, offset_ff,
                                              CNT_ONE, line_ff, column_inc);
               end
               push_in.count = push_in.count + 2'd1;
            end else begin
               in_word_in      = 1'b1;
               word_start_in   = offset_ff;
               word_length_in  = CNT_ONE;
               keyword_mask_in = keyword_keep(in_char_ff, 3'd0);
            end
         end

         if (push_in.count == 2'd1) begin
            push_in.first.last = 1'b1;
         end else if (push_in.count == 2'd2) begin
            push_in.second.last = 1'b1;
         end
      end
   end

   assign push = push_in;

   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_char_ff <= req_char;
         in_eot_ff  <= req_eot;
      end
      if (reset) begin
         in_valid_ff     <= 1'b0;
         in_word_ff      <= 1'b0;
         in_comment_ff   <= 1'b0;
         word_start_ff   <= '0;
         word_length_ff  <= '0;
         keyword_mask_ff <= '1;
         line_ff         <= CNT_ONE;
         column_ff       <= CNT_ONE;
         offset_ff       <= '0;
      end else begin
         in_valid_ff     <= in_valid_in;
         in_word_ff      <= in_word_in;
         in_comment_ff   <= in_comment_in;
         word_start_ff   <= word_start_in;
         word_length_ff  <= word_length_in;
         keyword_mask_ff <= keyword_mask_in;
         line_ff         <= line_in;
         column_ff       <= column_in;
         offset_ff       <= offset_in;
      end
   end

endmodule

// ===== rtl/core/ats_result_queue.sv =====
// ----------------------------------------------------------------------------
// ats_result_queue
// Small token queue: takes up to two tokens a cycle, hands out one while rsp_ready is high.
// ----------------------------------------------------------------------------
module ats_result_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  ats_pkg::push_type         push,
   output ats_pkg::queue_status_type status,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output ats_pkg::result_type       rsp_token
);
   import ats_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);

   result_type       entry_ff [QUEUE_DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff, count_in;
   logic             pop;

   assign rsp_valid = (count_ff != '0);
   assign rsp_token = entry_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;

   assign wr_ptr_in = wr_ptr_ff + AW'(push.count);
   assign rd_ptr_in = rd_ptr_ff + AW'(pop);
   assign count_in  = count_ff + (AW+1)'(push.count) - (AW+1)'(pop);

   assign status.count = 3'(count_ff);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_ff + AW'(1)] <= push.second;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/core/assembler_token_scanner_top.sv =====
// ----------------------------------------------------------------------------
// assembler_token_scanner_top
// Streaming scanner that turns source characters into assembler tokens.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one source character per transaction in
//   req_tdata; a transaction with req_tlast high marks the end of the text
//   and its character is ignored. The rsp_ channel returns one token per
//   transaction: its kind in rsp_tuser and offset, length, line and column
//   in rsp_tdata. rsp_tlast marks the final token caused by one character.
//   A token passes the input register and then the token queue before
//   it is valid on rsp_; the character waits in the input register while
//   the queue lacks room for two tokens.
//   Throughput: one character per cycle while the queue has room for two
//   tokens. A character that ends a word and is itself a token, or an end
//   marker after a word, yields two tokens; the rsp_ channel drains one
//   token per cycle from a four-entry queue while rsp_tready is high.
//   The scanner only processes a character when the queue has room for two
//   tokens, so req_tready falls while a character waits in the input
//   register and more than two tokens wait.
//   Reset (synchronous, active high) empties the queue and returns line and
//   column to 1 and offset to 0. When the receiver stalls, tokens wait in
//   the queue and characters keep being taken until it is nearly full.
// ----------------------------------------------------------------------------
module assembler_token_scanner_top #(
   parameter int COUNTER_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tlast,   // end_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [15:0] token_offset, [31:16] token_length,
                                    // [47:32] token_line, [63:48] token_column
   output logic [3:0]  rsp_tuser,   // [3:0] token_kind
   output logic        rsp_tlast    // last_of_run
);
   import ats_pkg::*;

   push_type         push;
   queue_status_type queue_status;
   result_type       token;
   logic             space_ok;

   // Room for two tokens means any character can be processed this cycle.
   assign space_ok = (queue_status.count <= 3'(QUEUE_DEPTH - 2));

   ats_scanner #(
      .CW (COUNTER_WIDTH)
   ) u_scanner (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_char   (req_tdata),
      .req_eot    (req_tlast),
      .space_ok   (space_ok),
      .push       (push)
   );

   ats_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .status    (queue_status),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_token (token)
   );

   assign rsp_tuser = token.kind;
   assign rsp_tdata = {token.column, token.line, token.length, token.offset};
   assign rsp_tlast = token.last;

   // A character never produces more than two tokens.
   a_push_count : assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd3)
      else $error("scanner produced more than two tokens for one character");

   // Tokens are only produced when the queue has room for them.
   a_push_room : assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> (queue_status.count <= 3'(QUEUE_DEPTH - 2)))
      else $error("token pushed into a queue without room");

   // Only the final token of a character carries the last-of-run mark.
   a_last_mark : assert property (@(posedge clock) disable iff (reset)
      ((push.count == 2'd2) |-> (!push.first.last && push.second.last)) and
      ((push.count == 2'd1) |-> push.first.last))
      else $error("last-of-run mark on the wrong token");

   // End-of-file tokens always have zero length and close their run.
   a_eof_shape : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == KIND_EOF)) |-> ((rsp_tdata[31:16] == 16'd0) && rsp_tlast))
      else $error("malformed end-of-file token");

endmodule
